// File: src/fractional_box_average_decimator_assert.svh
// ----------------------------------------------------------------------------
// fractional_box_average_decimator_assert
// Assertion macros shared by the decimator RTL.
// ----------------------------------------------------------------------------
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst_n is low.
`ifndef FRACTIONAL_BOX_AVERAGE_DECIMATOR_ASSERT_SVH
`define FRACTIONAL_BOX_AVERAGE_DECIMATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBAD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fbad_pkg.sv
// ----------------------------------------------------------------------------
// fbad_pkg
// Shared types and constants of the fractional-rate box-average decimator.
// ----------------------------------------------------------------------------
package fbad_pkg;

    localparam int DATA_W         = 16;
    localparam int RATIO_W        = 24;
    localparam int PHASE_W        = 26;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_WINDOW_DEF = 256;

    typedef struct packed {
        logic signed [DATA_W-1:0] left_sample;
        logic signed [DATA_W-1:0] right_sample;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] left_average;
        logic signed [DATA_W-1:0] right_average;
    } out_t;

endpackage

// File: src/fbad_div.sv
// ----------------------------------------------------------------------------
// fbad_div
// Bit-serial restoring divider that returns floor(numer / denom) for a
// two's complement numerator and a positive denominator, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module fbad_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NUM_W-1:0]                numer,
    input  logic [DEN_W-1:0]                denom,
    output logic                            done,
    output logic [fbad_pkg::DATA_W-1:0]     quotient
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] acc_reg;
    logic [NUM_W-1:0] acc_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DEN_W:0]   trial;
    logic             q_bit;
    logic             last_step;

    // A negative numerator is divided as its one's complement; inverting
    // the quotient afterward gives the floor.
    always_comb
    begin
        trial     = {rem_reg, acc_reg[NUM_W-1]};
        q_bit     = (trial >= {1'b0, den_reg});
        last_step = (step_reg == STEP_W'(NUM_W - 1));
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            acc_next  = numer[NUM_W-1] ? ~numer : numer;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = q_bit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            acc_next  = {acc_reg[NUM_W-2:0], q_bit};
            step_next = step_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= denom;
            neg_reg <= numer[NUM_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? ~acc_reg[fbad_pkg::DATA_W-1:0]
                              : acc_reg[fbad_pkg::DATA_W-1:0];

endmodule

// File: src/fractional_box_average_decimator.sv
// ----------------------------------------------------------------------------
// fractional_box_average_decimator
// Stereo box-average decimator with a fractional source-to-output ratio.
// ----------------------------------------------------------------------------
// Each input beat carries one left/right Q1.15 pair. The pair is added to the
// running sums of the open window in the cycle it is accepted. A signed phase
// with FRAC_BITS fraction bits tracks the distance to the next window
// boundary; when that distance rounds to zero or less, or when the window
// holds MAX_WINDOW samples, the window closes and one output beat carries the
// rounded-half-up means of both channels. A beat that does not close a window
// is taken without stalling the input. A beat that closes one starts two
// bit-serial dividers, one per channel, which deliver one quotient bit per
// cycle over the width of the doubled sum (26 steps at the default
// parameters); the input then stays stalled while they run and until the
// result is loaded into the output register, which waits only if it is
// still held by a stalled receiver. A finished result waits in the output
// register, so input beats that do not close a window are taken while it
// waits. The ratio_reg register is written through the cfg channel, which
// is always ready; values below 1.0 act as 1.0, and a new value takes effect
// at the next boundary.
`include "fractional_box_average_decimator_assert.svh"

module fractional_box_average_decimator #(
    parameter int FRAC_BITS  = fbad_pkg::FRAC_BITS_DEF,
    parameter int MAX_WINDOW = fbad_pkg::MAX_WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  fbad_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output fbad_pkg::out_t                 out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbad_pkg::RATIO_W-1:0]   cfg_data
);

    localparam int DATA_W  = fbad_pkg::DATA_W;
    localparam int RATIO_W = fbad_pkg::RATIO_W;
    localparam int PHASE_W = fbad_pkg::PHASE_W;
    // Sums are wide enough for MAX_WINDOW full-scale samples.
    localparam int SUM_W   = DATA_W + $clog2(MAX_WINDOW) + 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    // The divider sees 2*sum + n over 2*n.
    localparam int NUM_W   = SUM_W + 1;
    localparam int DEN_W   = CNT_W + 1;

    localparam logic signed [PHASE_W-1:0] ONE  = PHASE_W'(1) << FRAC_BITS;
    localparam logic signed [PHASE_W-1:0] HALF = PHASE_W'(1) << (FRAC_BITS - 1);
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1) << FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [RATIO_W-1:0]         ratio_reg;
    logic signed [PHASE_W-1:0]  phase_reg;
    logic signed [PHASE_W-1:0]  phase_next;
    logic signed [SUM_W-1:0]    lsum_reg;
    logic signed [SUM_W-1:0]    lsum_next;
    logic signed [SUM_W-1:0]    rsum_reg;
    logic signed [SUM_W-1:0]    rsum_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    fbad_pkg::out_t             out_data_reg;

    logic                       in_accept;
    logic                       boundary;
    logic                       full;
    logic                       emit;
    logic                       load_out;
    logic                       hold_open;
    logic [CNT_W-1:0]           count_inc;
    logic signed [SUM_W-1:0]    lsum_add;
    logic signed [SUM_W-1:0]    rsum_add;
    logic signed [PHASE_W-1:0]  ratio_eff;
    logic [NUM_W-1:0]           lnum;
    logic [NUM_W-1:0]           rnum;
    logic [DEN_W-1:0]           den;
    logic                       div_start;
    logic                       ldone;
    logic                       rdone;
    logic [DATA_W-1:0]          lquot;
    logic [DATA_W-1:0]          rquot;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    // A finished result whose output register is free this cycle.
    assign hold_open = (state_reg == ST_HOLD) && !out_valid_reg;

    always_comb
    begin
        // A ratio below 1.0 is treated as exactly 1.0.
        ratio_eff  = (PHASE_W'(ratio_reg) < ONE) ? ONE : $signed(PHASE_W'(ratio_reg));
        count_inc  = count_reg + CNT_W'(1);
        lsum_add   = lsum_reg + SUM_W'(in_data.left_sample);
        rsum_add   = rsum_reg + SUM_W'(in_data.right_sample);
        boundary   = (phase_reg < HALF);
        full       = (count_inc >= CNT_W'(MAX_WINDOW));
        emit       = boundary || full;
        phase_next = phase_reg + (boundary ? ratio_eff : PHASE_W'(0)) - ONE;
        lnum       = {lsum_add, 1'b0} + NUM_W'(count_inc);
        rnum       = {rsum_add, 1'b0} + NUM_W'(count_inc);
        den        = {count_inc, 1'b0};
        div_start  = in_accept && emit;
        load_out   = (state_reg == ST_HOLD) && (!out_valid_reg || !out_stall);

        lsum_next  = lsum_reg;
        rsum_next  = rsum_reg;
        count_next = count_reg;
        if (in_accept)
        begin
            if (emit)
            begin
                lsum_next  = '0;
                rsum_next  = '0;
                count_next = '0;
            end
            else
            begin
                lsum_next  = lsum_add;
                rsum_next  = rsum_add;
                count_next = count_inc;
            end
        end

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (ldone && rdone)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= RATIO_RESET;
            phase_reg     <= '0;
            lsum_reg      <= '0;
            rsum_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lsum_reg      <= lsum_next;
            rsum_reg      <= rsum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                phase_reg <= phase_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                ratio_reg <= cfg_data;
            end
        end
    end

    // The output payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.left_average  <= lquot;
            out_data_reg.right_average <= rquot;
        end
    end

    // One divider per channel; both run in lockstep.
    fbad_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (lnum),
        .denom    (den),
        .done     (ldone),
        .quotient (lquot)
    );

    fbad_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (rnum),
        .denom    (den),
        .done     (rdone),
        .quotient (rquot)
    );

    // The window never holds more than MAX_WINDOW samples.
    `FBAD_ASSERT_SAME(a_count_bound, 1'b1, count_reg < CNT_W'(MAX_WINDOW), "window count overflow")
    // The phase never drops below minus one half.
    `FBAD_ASSERT_SAME(a_phase_floor, 1'b1, phase_reg >= -HALF, "phase below lower bound")
    // A beat that closes a window starts the dividers and stalls the input.
    `FBAD_ASSERT_NEXT(a_div_start, div_start, state_reg == ST_DIV, "divide not started")
    // A held result with a free output register is presented next cycle.
    `FBAD_ASSERT_NEXT(a_hold_load, hold_open, out_valid_reg && !in_stall, "result not loaded")

endmodule
